### src/tbrl_pkg.sv
// shared types and constants of the token bucket rate limiter
package tbrl_pkg;

  localparam int TIME_W  = 48;
  localparam int BYTES_W = 16;
  localparam int RATE_W  = 32;
  localparam int WAIT_W  = 32;
  localparam int LEVEL_W = 64;
  localparam int HALF_W  = 24;              // elapsed time is multiplied in two halves
  localparam int PROD_W  = HALF_W + RATE_W; // one partial product
  localparam int ACC_W   = 82;              // level plus full growth, signed
  localparam int CAP_W   = 42;              // rate times one thousand
  localparam int DEBIT_W = 26;              // byte count times one thousand
  localparam int MILLI   = 1000;

  // what the back end has to do with one word
  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_RESTART,
    KIND_RUN
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [TIME_W-1:0]   elapsed;
    logic [BYTES_W-1:0]  byte_count;
  } cmd_t;

  typedef struct packed {
    logic [WAIT_W-1:0] wait_ms;
    logic              throttled;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_CAP,
    ST_SUB,
    ST_DIV_CHK,
    ST_DIV,
    ST_OUT
  } bstate_t;

endpackage

### src/token_bucket_rate_limiter_top.sv
// top level of the token bucket rate limiter
//
//   channel | handshake            | word
//   --------+----------------------+-----------------------------------------
//   in      | in_push / in_full    | in_restart, in_now_ms, in_byte_count
//   out     | out_pop / out_empty  | out_wait_ms, out_throttled
//   cfg     | cfg_valid/cfg_ready  | cfg_rate_bytes_per_s (always ready)
//
// restart and time-only words get their result in the cycle the back end takes them
// a bucket update holds the back end for multiply, add, cap, subtract and divide;
// with no deficit or a saturated wait it skips the restoring divider
// reset is synchronous, active low; token level and last time clear to zero
// the input stalls only when the command queue is full, the back end only
// when the result queue is full
module token_bucket_rate_limiter_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic                         in_restart,
  input  logic [tbrl_pkg::TIME_W-1:0]  in_now_ms,
  input  logic [tbrl_pkg::BYTES_W-1:0] in_byte_count,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [tbrl_pkg::WAIT_W-1:0]  out_wait_ms,
  output logic                         out_throttled,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tbrl_pkg::RATE_W-1:0]  cfg_rate_bytes_per_s
);

  logic [tbrl_pkg::RATE_W-1:0] rate_r, rate_nxt;
  tbrl_pkg::cmd_t              cmd_in, cmd_out;
  logic                        cmd_push, cmd_full, cmd_pop, cmd_empty;
  tbrl_pkg::result_t           res_in, res_out;
  logic                        res_push, res_full;

  // rate register
  assign cfg_ready = 1'b1;
  assign rate_nxt  = (cfg_valid && cfg_ready) ? cfg_rate_bytes_per_s : rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= '0;
    end else begin
      rate_r <= rate_nxt;
    end
  end

  tbrl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_restart    (in_restart),
    .in_now_ms     (in_now_ms),
    .in_byte_count (in_byte_count),
    .rate          (rate_r),
    .cmd_push      (cmd_push),
    .cmd_data      (cmd_in),
    .cmd_full      (cmd_full)
  );

  tbrl_fifo #(
    .WIDTH ($bits(tbrl_pkg::cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  tbrl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rate      (rate_r),
    .cmd_data  (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_in),
    .res_full  (res_full)
  );

  tbrl_fifo #(
    .WIDTH ($bits(tbrl_pkg::result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_wait_ms   = res_out.wait_ms;
  assign out_throttled = res_out.throttled;

endmodule

### src/tbrl_fifo.sv
// small register queue used between front, back and result port
module tbrl_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fifo count above depth");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("fifo pop did not lower the count");

endmodule

### src/tbrl_front.sv
// front end: takes input words, tracks the last time and classifies each word
module tbrl_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic                         in_restart,
  input  logic [tbrl_pkg::TIME_W-1:0]  in_now_ms,
  input  logic [tbrl_pkg::BYTES_W-1:0] in_byte_count,
  input  logic [tbrl_pkg::RATE_W-1:0]  rate,
  output logic                         cmd_push,
  output tbrl_pkg::cmd_t               cmd_data,
  input  logic                         cmd_full
);

  logic [tbrl_pkg::TIME_W-1:0] last_time_r, last_time_nxt;
  logic                        accept;

  assign in_full  = cmd_full;
  assign accept   = in_push && !cmd_full;
  assign cmd_push = accept;

  // classify: restart, record time only, or full bucket update
  always_comb begin
    cmd_data.elapsed    = in_now_ms - last_time_r;
    cmd_data.byte_count = in_byte_count;
    if (in_restart) begin
      cmd_data.kind = tbrl_pkg::KIND_RESTART;
    end else if (rate == '0 || last_time_r == '0 || in_now_ms <= last_time_r) begin
      cmd_data.kind = tbrl_pkg::KIND_PASS;
    end else begin
      cmd_data.kind = tbrl_pkg::KIND_RUN;
    end
    last_time_nxt = accept ? in_now_ms : last_time_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
    end else begin
      last_time_r <= last_time_nxt;
    end
  end

endmodule

### src/tbrl_back.sv
// back end: token level update, multiply in halves and restoring divide
module tbrl_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tbrl_pkg::RATE_W-1:0] rate,
  input  tbrl_pkg::cmd_t              cmd_data,
  input  logic                        cmd_empty,
  output logic                        cmd_pop,
  output logic                        res_push,
  output tbrl_pkg::result_t           res_data,
  input  logic                        res_full
);

  localparam int TIME_W  = tbrl_pkg::TIME_W;
  localparam int BYTES_W = tbrl_pkg::BYTES_W;
  localparam int RATE_W  = tbrl_pkg::RATE_W;
  localparam int WAIT_W  = tbrl_pkg::WAIT_W;
  localparam int LEVEL_W = tbrl_pkg::LEVEL_W;
  localparam int HALF_W  = tbrl_pkg::HALF_W;
  localparam int PROD_W  = tbrl_pkg::PROD_W;
  localparam int ACC_W   = tbrl_pkg::ACC_W;
  localparam int CAP_W   = tbrl_pkg::CAP_W;
  localparam int DEBIT_W = tbrl_pkg::DEBIT_W;
  localparam int CNT_W   = $clog2(WAIT_W);

  tbrl_pkg::bstate_t state_r, state_nxt;

  logic signed [LEVEL_W-1:0] level_r, level_nxt;
  logic        [TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic        [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic        [PROD_W-1:0]  pp_lo_r, pp_lo_nxt;
  logic        [PROD_W-1:0]  pp_hi_r, pp_hi_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic        [RATE_W-1:0]  rem_r, rem_nxt;
  logic        [WAIT_W-1:0]  quo_r, quo_nxt;
  logic        [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic        [CAP_W-1:0]   cap;
  logic        [DEBIT_W-1:0] debit;
  logic signed [LEVEL_W:0]   diff;
  logic        [LEVEL_W-1:0] mag;
  logic        [RATE_W:0]    shifted;
  logic                      ge;

  // constant multiplies and divider step
  assign cap     = CAP_W'(rate) * CAP_W'(tbrl_pkg::MILLI);
  assign debit   = DEBIT_W'(bytes_r) * DEBIT_W'(tbrl_pkg::MILLI);
  assign diff    = (LEVEL_W + 1)'(level_r) - $signed({{(LEVEL_W + 1 - DEBIT_W){1'b0}}, debit});
  assign mag     = '0 - level_r;
  assign shifted = {rem_r, quo_r[WAIT_W-1]};
  assign ge      = (shifted >= {1'b0, rate});

  // sequencer and datapath next values
  always_comb begin
    state_nxt         = state_r;
    level_nxt         = level_r;
    elapsed_nxt       = elapsed_r;
    bytes_nxt         = bytes_r;
    pp_lo_nxt         = pp_lo_r;
    pp_hi_nxt         = pp_hi_r;
    acc_nxt           = acc_r;
    rem_nxt           = rem_r;
    quo_nxt           = quo_r;
    cnt_nxt           = cnt_r;
    cmd_pop           = 1'b0;
    res_push          = 1'b0;
    res_data.wait_ms  = quo_r;
    res_data.throttled = (quo_r != '0);
    case (state_r)
      tbrl_pkg::ST_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop            = 1'b1;
          res_data.wait_ms   = '0;
          res_data.throttled = 1'b0;
          case (cmd_data.kind)
            tbrl_pkg::KIND_RESTART: begin
              level_nxt = '0;
              res_push  = 1'b1;
            end
            tbrl_pkg::KIND_RUN: begin
              elapsed_nxt = cmd_data.elapsed;
              bytes_nxt   = cmd_data.byte_count;
              state_nxt   = tbrl_pkg::ST_MUL_LO;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      tbrl_pkg::ST_MUL_LO: begin
        pp_lo_nxt = elapsed_r[HALF_W-1:0] * rate;
        state_nxt = tbrl_pkg::ST_MUL_HI;
      end
      tbrl_pkg::ST_MUL_HI: begin
        pp_hi_nxt = elapsed_r[TIME_W-1:HALF_W] * rate;
        acc_nxt   = ACC_W'(level_r) + $signed({{(ACC_W - PROD_W){1'b0}}, pp_lo_r});
        state_nxt = tbrl_pkg::ST_ACC;
      end
      tbrl_pkg::ST_ACC: begin
        acc_nxt   = acc_r
                  + $signed({{(ACC_W - PROD_W - HALF_W){1'b0}}, pp_hi_r, {HALF_W{1'b0}}});
        state_nxt = tbrl_pkg::ST_CAP;
      end
      tbrl_pkg::ST_CAP: begin
        // growth is never negative, so the capped sum fits the level
        if (acc_r > $signed({{(ACC_W - CAP_W){1'b0}}, cap})) begin
          level_nxt = $signed({{(LEVEL_W - CAP_W){1'b0}}, cap});
        end else begin
          level_nxt = acc_r[LEVEL_W-1:0];
        end
        state_nxt = tbrl_pkg::ST_SUB;
      end
      tbrl_pkg::ST_SUB: begin
        // saturate at the most negative level
        if (diff[LEVEL_W] != diff[LEVEL_W-1]) begin
          level_nxt = {1'b1, {(LEVEL_W - 1){1'b0}}};
        end else begin
          level_nxt = diff[LEVEL_W-1:0];
        end
        state_nxt = tbrl_pkg::ST_DIV_CHK;
      end
      tbrl_pkg::ST_DIV_CHK: begin
        if (!level_r[LEVEL_W-1]) begin
          quo_nxt   = '0;
          state_nxt = tbrl_pkg::ST_OUT;
        end else if (mag[LEVEL_W-1:WAIT_W] >= rate) begin
          // quotient does not fit the wait field
          quo_nxt   = '1;
          state_nxt = tbrl_pkg::ST_OUT;
        end else begin
          rem_nxt   = mag[LEVEL_W-1:WAIT_W];
          quo_nxt   = mag[WAIT_W-1:0];
          cnt_nxt   = '1;
          state_nxt = tbrl_pkg::ST_DIV;
        end
      end
      tbrl_pkg::ST_DIV: begin
        // one quotient bit per cycle
        rem_nxt = ge ? RATE_W'(shifted - {1'b0, rate}) : shifted[RATE_W-1:0];
        quo_nxt = {quo_r[WAIT_W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = tbrl_pkg::ST_OUT;
        end
      end
      tbrl_pkg::ST_OUT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = tbrl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tbrl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tbrl_pkg::ST_IDLE;
      level_r <= '0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    elapsed_r <= elapsed_nxt;
    bytes_r   <= bytes_nxt;
    pp_lo_r   <= pp_lo_nxt;
    pp_hi_r   <= pp_hi_nxt;
    acc_r     <= acc_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    cnt_r     <= cnt_nxt;
  end

  a_rem_below_rate: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tbrl_pkg::ST_DIV) |-> (rem_r < rate))
    else $error("divider remainder not below rate");

  a_level_capped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tbrl_pkg::ST_DIV_CHK)
      |-> (level_r <= $signed({{(LEVEL_W - CAP_W){1'b0}}, cap})))
    else $error("token level above one second of rate");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tbrl_pkg::ST_DIV && cnt_r == '0) |=> (state_r == tbrl_pkg::ST_OUT))
    else $error("divider did not hand over its result");

endmodule
